/* src/vrp_pkg.sv */
`default_nettype none
package vrp_pkg;

   localparam int COORD_W         = 24;
   localparam int TRIG_W          = 16;
   localparam int FOCAL_W         = 23;
   localparam int CENTRE_W        = 12;
   localparam int CSR_IDX_W       = 4;
   localparam int COORD_FRAC_BITS = 12;
   localparam int TRIG_FRAC_BITS  = 14;
   localparam int ROT_PROD_W      = COORD_W + TRIG_W;
   localparam int ROT_SUM_W       = ROT_PROD_W + 1;
   localparam int PROJ_PROD_W     = 48;
   localparam int MAG_W           = 47;
   localparam int DEN_W           = 24;
   localparam int QUO_BITS        = 26;
   localparam int QSUM_W          = QUO_BITS + 2;
   localparam int PIPE_LATENCY    = QUO_BITS + 3;

   localparam logic signed [PROJ_PROD_W-1:0] F_MAX = 48'sd8388607;
   localparam logic signed [PROJ_PROD_W-1:0] F_MIN = -48'sd8388608;

   typedef enum logic [1:0] {
      OP_ROT_X   = 2'd0,
      OP_ROT_Y   = 2'd1,
      OP_ROT_Z   = 2'd2,
      OP_PROJECT = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] REG_COS_X  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_X  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_Y  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_Y  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COS_Z  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_Z  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE = 4'd7;

   typedef struct packed {
      logic [TRIG_W-1:0]   cos_x;
      logic [TRIG_W-1:0]   sin_x;
      logic [TRIG_W-1:0]   cos_y;
      logic [TRIG_W-1:0]   sin_y;
      logic [TRIG_W-1:0]   cos_z;
      logic [TRIG_W-1:0]   sin_z;
      logic [FOCAL_W-1:0]  focal;
      logic [CENTRE_W-1:0] centre;
   } cfg_type;

   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic [DEN_W-1:0]    rem;
      logic [QUO_BITS-1:0] dvd;
      logic [QUO_BITS-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic               proj;
      logic               behind;
      logic               sat;
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic [COORD_W-1:0] c;
      logic [DEN_W-1:0]   den;
      lane_type           lx;
      lane_type           ly;
   } beat_type;

   function automatic logic [COORD_W:0] sat_fn(input logic signed [PROJ_PROD_W-1:0] v);
      logic [COORD_W:0] r;
      if (v > F_MAX) begin
         r = {1'b1, F_MAX[COORD_W-1:0]};
      end else if (v < F_MIN) begin
         r = {1'b1, F_MIN[COORD_W-1:0]};
      end else begin
         r = {1'b0, v[COORD_W-1:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/vertex_rotate_project_core.sv */
// channel   direction  handshake                  payload
// req       in         start & !busy              req_opcode, req_coord_x/y/z
// rsp       out        rsp_valid (one cycle)      rsp_out_a/b/c, rsp_behind_viewer,
//                                                 rsp_saturated
// csr       in         csr_valid & csr_ready      csr_index, csr_data
//
// one beat accepted per cycle while busy is low; rsp_valid rises when the beat reaches
// the output register
// the pipe is set by the divider chain: one quotient bit per cell, 26 cells,
// plus product, setup and output stages
// reset is synchronous; it empties the pipe and loads the register reset values
// busy is a registered copy of reset, so it falls in the cycle after reset falls; the receiver cannot stall
`default_nettype none
module vertex_rotate_project_core
   import vrp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [COORD_W-1:0]   req_coord_x,
   input  wire logic [COORD_W-1:0]   req_coord_y,
   input  wire logic [COORD_W-1:0]   req_coord_z,
   output logic                      rsp_valid,
   output logic [COORD_W-1:0]        rsp_out_a,
   output logic [COORD_W-1:0]        rsp_out_b,
   output logic [COORD_W-1:0]        rsp_out_c,
   output logic                      rsp_behind_viewer,
   output logic                      rsp_saturated,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FOCAL_W-1:0]   csr_data
);

   logic     busy_ff;
   cfg_type  cfg_ff;
   logic     accept;
   beat_type chain [0:QUO_BITS];

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign accept    = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_x  <= 16'd16384;
         cfg_ff.sin_x  <= '0;
         cfg_ff.cos_y  <= 16'd16384;
         cfg_ff.sin_y  <= '0;
         cfg_ff.cos_z  <= 16'd16384;
         cfg_ff.sin_z  <= '0;
         cfg_ff.focal  <= 23'd3174400;
         cfg_ff.centre <= 12'd400;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COS_X:  cfg_ff.cos_x  <= csr_data[TRIG_W-1:0];
            REG_SIN_X:  cfg_ff.sin_x  <= csr_data[TRIG_W-1:0];
            REG_COS_Y:  cfg_ff.cos_y  <= csr_data[TRIG_W-1:0];
            REG_SIN_Y:  cfg_ff.sin_y  <= csr_data[TRIG_W-1:0];
            REG_COS_Z:  cfg_ff.cos_z  <= csr_data[TRIG_W-1:0];
            REG_SIN_Z:  cfg_ff.sin_z  <= csr_data[TRIG_W-1:0];
            REG_FOCAL:  cfg_ff.focal  <= csr_data;
            REG_CENTRE: cfg_ff.centre <= csr_data[CENTRE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   vrp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .opcode  (req_opcode),
      .coord_x (req_coord_x),
      .coord_y (req_coord_y),
      .coord_z (req_coord_z),
      .cfg     (cfg_ff),
      .beat    (chain[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      vrp_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (chain[i]),
         .beat_o (chain[i+1])
      );
   end

   vrp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .beat   (chain[QUO_BITS]),
      .centre (cfg_ff.centre),
      .valid  (rsp_valid),
      .out_a  (rsp_out_a),
      .out_b  (rsp_out_b),
      .out_c  (rsp_out_c),
      .behind (rsp_behind_viewer),
      .sat    (rsp_saturated)
   );

endmodule
`default_nettype wire

/* src/vrp_front.sv */
`default_nettype none
module vrp_front
   import vrp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [1:0]         opcode,
   input  wire logic [COORD_W-1:0] coord_x,
   input  wire logic [COORD_W-1:0] coord_y,
   input  wire logic [COORD_W-1:0] coord_z,
   input  wire cfg_type            cfg,
   output beat_type                beat
);

   localparam logic signed [ROT_SUM_W-1:0] ROUND_HALF = ROT_SUM_W'(1 << (TRIG_FRAC_BITS - 1));

   opcode_type                    op;
   logic        [COORD_W-1:0]     u;
   logic        [COORD_W-1:0]     v;
   logic        [TRIG_W-1:0]      co;
   logic        [TRIG_W-1:0]      si;

   // stage 1: products
   logic                          s1_valid_ff;
   opcode_type                    s1_op_ff;
   logic        [COORD_W-1:0]     s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [ROT_PROD_W-1:0]  s1_m0_ff, s1_m1_ff, s1_m2_ff, s1_m3_ff;
   logic signed [PROJ_PROD_W-1:0] s1_px_ff, s1_py_ff;
   logic signed [DEN_W:0]         s1_den_ff;

   logic signed [ROT_PROD_W-1:0]  m0_in, m1_in, m2_in, m3_in;
   logic signed [PROJ_PROD_W-1:0] px_in, py_in;
   logic signed [DEN_W:0]         den_in;

   // stage 2: sums, rounding, divider setup
   logic signed [ROT_SUM_W-1:0]   sum1, sum2, rnd1, rnd2;
   logic        [COORD_W:0]       sat1, sat2;
   logic        [COORD_W:0]       pass_a, pass_b, pass_c;
   lane_type                      lx_in, ly_in;
   beat_type                      beat_in, beat_ff;

   always_comb begin
      op = opcode_type'(opcode);
      case (op)
         OP_ROT_X: begin
            u = coord_y; v = coord_z; co = cfg.cos_x; si = cfg.sin_x;
         end
         OP_ROT_Y: begin
            u = coord_x; v = coord_z; co = cfg.cos_y; si = cfg.sin_y;
         end
         OP_ROT_Z: begin
            u = coord_x; v = coord_y; co = cfg.cos_z; si = cfg.sin_z;
         end
         default: begin
            u = coord_x; v = coord_y; co = cfg.cos_z; si = cfg.sin_z;
         end
      endcase
      m0_in  = $signed(u) * $signed(co);
      m1_in  = $signed(v) * $signed(si);
      m2_in  = $signed(v) * $signed(co);
      m3_in  = $signed(u) * $signed(si);
      px_in  = $signed({{(PROJ_PROD_W-COORD_W){coord_x[COORD_W-1]}}, coord_x})
               * $signed({{(PROJ_PROD_W-FOCAL_W){1'b0}}, cfg.focal});
      py_in  = $signed({{(PROJ_PROD_W-COORD_W){coord_y[COORD_W-1]}}, coord_y})
               * $signed({{(PROJ_PROD_W-FOCAL_W){1'b0}}, cfg.focal});
      den_in = $signed({2'b00, cfg.focal}) + $signed({coord_z[COORD_W-1], coord_z});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_op_ff  <= op;
      s1_x_ff   <= coord_x;
      s1_y_ff   <= coord_y;
      s1_z_ff   <= coord_z;
      s1_m0_ff  <= m0_in;
      s1_m1_ff  <= m1_in;
      s1_m2_ff  <= m2_in;
      s1_m3_ff  <= m3_in;
      s1_px_ff  <= px_in;
      s1_py_ff  <= py_in;
      s1_den_ff <= den_in;
   end

   function automatic lane_type lane_setup(input logic signed [PROJ_PROD_W-1:0] p,
                                           input logic [DEN_W-1:0] den);
      lane_type         l;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] n;
      l.neg = p[PROJ_PROD_W-1];
      mag   = l.neg ? MAG_W'(-p) : p[MAG_W-1:0];
      n     = mag + MAG_W'(den >> 1);
      l.ovf = {3'b000, n[MAG_W-1:QUO_BITS]} >= den;
      l.rem = {3'b000, n[MAG_W-1:QUO_BITS]};
      l.dvd = n[QUO_BITS-1:0];
      l.quo = '0;
      return l;
   endfunction

   always_comb begin
      if (s1_op_ff == OP_ROT_Y) begin
         sum1 = ROT_SUM_W'(s1_m0_ff) - ROT_SUM_W'(s1_m1_ff);
         sum2 = ROT_SUM_W'(s1_m2_ff) + ROT_SUM_W'(s1_m3_ff);
      end else begin
         sum1 = ROT_SUM_W'(s1_m0_ff) + ROT_SUM_W'(s1_m1_ff);
         sum2 = ROT_SUM_W'(s1_m2_ff) - ROT_SUM_W'(s1_m3_ff);
      end
      rnd1   = (sum1 + ROUND_HALF) >>> TRIG_FRAC_BITS;
      rnd2   = (sum2 + ROUND_HALF) >>> TRIG_FRAC_BITS;
      sat1   = sat_fn(PROJ_PROD_W'(rnd1));
      sat2   = sat_fn(PROJ_PROD_W'(rnd2));
      pass_a = {1'b0, s1_x_ff};
      pass_b = {1'b0, s1_y_ff};
      pass_c = {1'b0, s1_z_ff};
      lx_in  = lane_setup(s1_px_ff, s1_den_ff[DEN_W-1:0]);
      ly_in  = lane_setup(s1_py_ff, s1_den_ff[DEN_W-1:0]);

      beat_in        = '0;
      beat_in.valid  = s1_valid_ff;
      beat_in.proj   = (s1_op_ff == OP_PROJECT);
      beat_in.behind = (s1_den_ff <= 0);
      beat_in.den    = s1_den_ff[DEN_W-1:0];
      beat_in.lx     = lx_in;
      beat_in.ly     = ly_in;
      case (s1_op_ff)
         OP_ROT_X: begin
            beat_in.a   = pass_a[COORD_W-1:0];
            beat_in.b   = sat1[COORD_W-1:0];
            beat_in.c   = sat2[COORD_W-1:0];
            beat_in.sat = sat1[COORD_W] | sat2[COORD_W];
         end
         OP_ROT_Y: begin
            beat_in.a   = sat1[COORD_W-1:0];
            beat_in.b   = pass_b[COORD_W-1:0];
            beat_in.c   = sat2[COORD_W-1:0];
            beat_in.sat = sat1[COORD_W] | sat2[COORD_W];
         end
         OP_ROT_Z: begin
            beat_in.a   = sat1[COORD_W-1:0];
            beat_in.b   = sat2[COORD_W-1:0];
            beat_in.c   = pass_c[COORD_W-1:0];
            beat_in.sat = sat1[COORD_W] | sat2[COORD_W];
         end
         default: begin
            beat_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.proj   <= beat_in.proj;
      beat_ff.behind <= beat_in.behind;
      beat_ff.sat    <= beat_in.sat;
      beat_ff.a      <= beat_in.a;
      beat_ff.b      <= beat_in.b;
      beat_ff.c      <= beat_in.c;
      beat_ff.den    <= beat_in.den;
      beat_ff.lx     <= beat_in.lx;
      beat_ff.ly     <= beat_in.ly;
   end

   assign beat = beat_ff;

endmodule
`default_nettype wire

/* src/vrp_div_cell.sv */
`default_nettype none
module vrp_div_cell
   import vrp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire beat_type beat_i,
   output beat_type      beat_o
);

   beat_type beat_in, beat_ff;

   function automatic lane_type lane_step(input lane_type l, input logic [DEN_W-1:0] den);
      lane_type     r;
      logic [DEN_W:0] t;
      logic         ge;
      t     = {l.rem, l.dvd[QUO_BITS-1]};
      ge    = t >= {1'b0, den};
      r     = l;
      r.rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
      r.dvd = {l.dvd[QUO_BITS-2:0], 1'b0};
      r.quo = {l.quo[QUO_BITS-2:0], ge};
      return r;
   endfunction

   always_comb begin
      beat_in    = beat_i;
      beat_in.lx = lane_step(beat_i.lx, beat_i.den);
      beat_in.ly = lane_step(beat_i.ly, beat_i.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.proj   <= beat_in.proj;
      beat_ff.behind <= beat_in.behind;
      beat_ff.sat    <= beat_in.sat;
      beat_ff.a      <= beat_in.a;
      beat_ff.b      <= beat_in.b;
      beat_ff.c      <= beat_in.c;
      beat_ff.den    <= beat_in.den;
      beat_ff.lx     <= beat_in.lx;
      beat_ff.ly     <= beat_in.ly;
   end

   assign beat_o = beat_ff;

endmodule
`default_nettype wire

/* src/vrp_back.sv */
`default_nettype none
module vrp_back
   import vrp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire beat_type            beat,
   input  wire logic [CENTRE_W-1:0] centre,
   output logic                     valid,
   output logic [COORD_W-1:0]       out_a,
   output logic [COORD_W-1:0]       out_b,
   output logic [COORD_W-1:0]       out_c,
   output logic                     behind,
   output logic                     sat
);

   logic               valid_ff;
   logic [COORD_W-1:0] a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic               behind_ff, sat_ff, behind_in, sat_in;
   logic [COORD_W:0]   pa, pb;

   function automatic logic [COORD_W:0] finish(input lane_type l,
                                               input logic [CENTRE_W-1:0] ctr);
      logic signed [QSUM_W-1:0] qs;
      logic signed [QSUM_W-1:0] s;
      logic [COORD_W:0]         r;
      qs = l.neg ? -$signed({2'b00, l.quo}) : $signed({2'b00, l.quo});
      s  = qs + $signed({{(QSUM_W-CENTRE_W-COORD_FRAC_BITS){1'b0}}, ctr,
                         {COORD_FRAC_BITS{1'b0}}});
      if (l.ovf) begin
         r = l.neg ? {1'b1, F_MIN[COORD_W-1:0]} : {1'b1, F_MAX[COORD_W-1:0]};
      end else begin
         r = sat_fn(PROJ_PROD_W'(s));
      end
      return r;
   endfunction

   always_comb begin
      pa = finish(beat.lx, centre);
      pb = finish(beat.ly, centre);
      if (!beat.proj) begin
         a_in = beat.a; b_in = beat.b; c_in = beat.c;
         behind_in = 1'b0;
         sat_in    = beat.sat;
      end else if (beat.behind) begin
         a_in = '0; b_in = '0; c_in = '0;
         behind_in = 1'b1;
         sat_in    = 1'b0;
      end else begin
         a_in = pa[COORD_W-1:0];
         b_in = pb[COORD_W-1:0];
         c_in = '0;
         behind_in = 1'b0;
         sat_in    = pa[COORD_W] | pb[COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat.valid;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      behind_ff <= behind_in;
      sat_ff    <= sat_in;
   end

   assign valid  = valid_ff;
   assign out_a  = a_ff;
   assign out_b  = b_ff;
   assign out_c  = c_ff;
   assign behind = behind_ff;
   assign sat    = sat_ff;

endmodule
`default_nettype wire

/* src/vrp_checker.sv */
`default_nettype none
module vrp_checker
   import vrp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic [COORD_W-1:0] rsp_out_a,
   input wire logic [COORD_W-1:0] rsp_out_b,
   input wire logic [COORD_W-1:0] rsp_out_c,
   input wire logic               rsp_behind_viewer,
   input wire logic               rsp_saturated
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("response beat missing at fixed latency");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_behind_viewer) |->
         (rsp_out_a == '0 && rsp_out_b == '0 && rsp_out_c == '0 && !rsp_saturated))
      else $error("behind-viewer beat with nonzero payload");

   a_no_busy_run: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held outside reset");

endmodule

bind vertex_rotate_project_core vrp_checker u_vrp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_out_a         (rsp_out_a),
   .rsp_out_b         (rsp_out_b),
   .rsp_out_c         (rsp_out_c),
   .rsp_behind_viewer (rsp_behind_viewer),
   .rsp_saturated     (rsp_saturated)
);
`default_nettype wire

/* dv/vertex_rotate_project_checker.sv */
`timescale 1ns / 100ps
module vertex_rotate_project_checker
   import vrp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [COORD_W-1:0]   req_coord_x,
   input  wire logic [COORD_W-1:0]   req_coord_y,
   input  wire logic [COORD_W-1:0]   req_coord_z,
   input  wire logic                 rsp_valid,
   input  wire logic [COORD_W-1:0]   rsp_out_a,
   input  wire logic [COORD_W-1:0]   rsp_out_b,
   input  wire logic [COORD_W-1:0]   rsp_out_c,
   input  wire logic                 rsp_behind_viewer,
   input  wire logic                 rsp_saturated,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FOCAL_W-1:0]   csr_data,
   output int                        pending,
   output int                        fail_count
);

   localparam longint COORD_HI = 8388607;
   localparam longint COORD_LO = -8388608;

   typedef struct packed {
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic [COORD_W-1:0] c;
      logic               behind;
      logic               sat;
   } vertex_result_type;

   logic [TRIG_W-1:0]   trig_reg [8];
   logic [FOCAL_W-1:0]  focal_reg;
   logic [CENTRE_W-1:0] centre_reg;
   vertex_result_type   expected_vertices [$];
   int                  errors;

   // msb of the return value flags a clipped result
   function automatic logic [COORD_W:0] clamp_coord(longint v);
      if (v > COORD_HI) begin
         return {1'b1, COORD_HI[COORD_W-1:0]};
      end
      if (v < COORD_LO) begin
         return {1'b1, COORD_LO[COORD_W-1:0]};
      end
      return {1'b0, v[COORD_W-1:0]};
   endfunction

   // round half up
   function automatic longint round_trig(longint v);
      return (v + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
   endfunction

   // round half away from zero, den > 0
   function automatic longint rounded_quotient(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic vertex_result_type transform_vertex(opcode_type op,
                                                          logic signed [COORD_W-1:0] x,
                                                          logic signed [COORD_W-1:0] y,
                                                          logic signed [COORD_W-1:0] z);
      vertex_result_type r;
      longint vx, vy, vz, co, si, f, den, ctr, ra, rb, rc;
      logic [COORD_W:0] ta, tb, tc;
      logic [2:0] sel;
      vx = x;
      vy = y;
      vz = z;
      r = '0;
      if (op == OP_PROJECT) begin
         f = longint'(focal_reg);
         den = f + vz;
         if (den <= 0) begin
            r.behind = 1'b1;
         end else begin
            ctr = longint'(centre_reg) <<< COORD_FRAC_BITS;
            ta = clamp_coord(rounded_quotient(f * vx, den) + ctr);
            tb = clamp_coord(rounded_quotient(f * vy, den) + ctr);
            r.a = ta[COORD_W-1:0];
            r.b = tb[COORD_W-1:0];
            r.sat = ta[COORD_W] | tb[COORD_W];
         end
      end else begin
         sel = {op, 1'b0};
         co = longint'($signed(trig_reg[sel]));
         si = longint'($signed(trig_reg[sel | 3'd1]));
         ra = vx;
         rb = vy;
         rc = vz;
         case (op)
            OP_ROT_X: begin
               rb = round_trig(vy * co + vz * si);
               rc = round_trig(vz * co - vy * si);
            end
            OP_ROT_Y: begin
               ra = round_trig(vx * co - vz * si);
               rc = round_trig(vx * si + vz * co);
            end
            default: begin
               ra = round_trig(vx * co + vy * si);
               rb = round_trig(vy * co - vx * si);
            end
         endcase
         ta = clamp_coord(ra);
         tb = clamp_coord(rb);
         tc = clamp_coord(rc);
         r.a = ta[COORD_W-1:0];
         r.b = tb[COORD_W-1:0];
         r.c = tc[COORD_W-1:0];
         r.sat = ta[COORD_W] | tb[COORD_W] | tc[COORD_W];
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      vertex_result_type want;
      if (reset) begin
         trig_reg[REG_COS_X[2:0]] = 16'd16384;
         trig_reg[REG_SIN_X[2:0]] = '0;
         trig_reg[REG_COS_Y[2:0]] = 16'd16384;
         trig_reg[REG_SIN_Y[2:0]] = '0;
         trig_reg[REG_COS_Z[2:0]] = 16'd16384;
         trig_reg[REG_SIN_Z[2:0]] = '0;
         focal_reg = 23'd3174400;
         centre_reg = 12'd400;
         expected_vertices.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_vertices.size() == 0) begin
               errors++;
               $display("%0t: result beat expected none actual a %h b %h c %h",
                        $time, rsp_out_a, rsp_out_b, rsp_out_c);
            end else begin
               want = expected_vertices.pop_front();
               check_field("out_a", want.a, rsp_out_a);
               check_field("out_b", want.b, rsp_out_b);
               check_field("out_c", want.c, rsp_out_c);
               check_field("behind_viewer", COORD_W'(want.behind), COORD_W'(rsp_behind_viewer));
               check_field("saturated", COORD_W'(want.sat), COORD_W'(rsp_saturated));
            end
         end
         if (start && !busy) begin
            expected_vertices.push_back(transform_vertex(opcode_type'(req_opcode),
                                                         req_coord_x, req_coord_y, req_coord_z));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_COS_X, REG_SIN_X, REG_COS_Y, REG_SIN_Y, REG_COS_Z, REG_SIN_Z: begin
                  trig_reg[csr_index[2:0]] = csr_data[TRIG_W-1:0];
               end
               REG_FOCAL: begin
                  focal_reg = csr_data;
               end
               REG_CENTRE: begin
                  centre_reg = csr_data[CENTRE_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending <= expected_vertices.size();
      fail_count <= errors;
   end

endmodule

/* dv/vertex_rotate_project_core_tb.sv */
`timescale 1ns / 100ps
module vertex_rotate_project_core_tb;
   import vrp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 325;
   localparam int VERTEX_SPAN = 1000 << COORD_FRAC_BITS;
   localparam logic [COORD_W-1:0] COORD_MAX = 24'h7fffff;
   localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_TOP = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_opcode;
   logic [COORD_W-1:0]   req_coord_x;
   logic [COORD_W-1:0]   req_coord_y;
   logic [COORD_W-1:0]   req_coord_z;
   logic                 rsp_valid;
   logic [COORD_W-1:0]   rsp_out_a;
   logic [COORD_W-1:0]   rsp_out_b;
   logic [COORD_W-1:0]   rsp_out_c;
   logic                 rsp_behind_viewer;
   logic                 rsp_saturated;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FOCAL_W-1:0]   csr_data;
   int                   pending;
   int                   fail_count;
   int                   cycle_count;
   int                   cur_focal;

   always #5 clock = ~clock;

   vertex_rotate_project_core u_top (.*);

   vertex_rotate_project_checker u_checker (.*);

   task automatic send_vertex(opcode_type op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
      start <= 1'b1;
      req_opcode <= op;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [FOCAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_FOCAL) begin
         cur_focal = int'(data);
      end
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return COORD_W'($urandom);
         default: return COORD_W'(int'($urandom_range(0, 2 * VERTEX_SPAN)) - VERTEX_SPAN);
      endcase
   endfunction

   function automatic logic [FOCAL_W-1:0] pick_trig();
      logic [TRIG_W-1:0] t;
      case ($urandom_range(0, 7))
         0: t = 16'h4000;
         1: t = 16'hc000;
         2: t = '0;
         3: t = 16'h8000;
         default: t = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
      endcase
      return {(FOCAL_W - TRIG_W)'($urandom), t};
   endfunction

   function automatic logic [FOCAL_W-1:0] pick_focal();
      case ($urandom_range(0, 9))
         0: return 23'd4096;
         1: return 23'h7fffff;
         2: return '0;
         default: return FOCAL_W'($urandom_range(4096, 6144000));
      endcase
   endfunction

   task automatic randomize_registers();
      for (int i = REG_COS_X; i <= REG_SIN_Z; i++) begin
         write_reg(CSR_IDX_W'(i), pick_trig());
      end
      write_reg(REG_FOCAL, pick_focal());
      write_reg(REG_CENTRE, {(FOCAL_W - CENTRE_W)'($urandom), CENTRE_W'($urandom)});
      write_reg(CSR_IDX_W'($urandom_range(REG_CENTRE + 1, REG_INDEX_TOP)), FOCAL_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_vertex();
      opcode_type op;
      logic [COORD_W-1:0] z;
      op = opcode_type'($urandom_range(0, 3));
      z = rand_coord();
      if (op == OP_PROJECT && $urandom_range(0, 9) < 7) begin
         z = COORD_W'(int'($urandom_range(0, VERTEX_SPAN)) - cur_focal / 2);
      end
      send_vertex(op, rand_coord(), rand_coord(), z);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int burst_left;
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= OP_ROT_X;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_COS_X;
      csr_data <= '0;
      cur_focal = 3174400;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: identity rotation, default focal and centre
      send_vertex(OP_ROT_X, COORD_MAX, COORD_MIN, 24'h000001);
      send_vertex(OP_ROT_Y, COORD_MIN, COORD_MAX, COORD_MAX);
      send_vertex(OP_ROT_Z, 24'h000001, COORD_MIN, COORD_MIN);
      send_vertex(OP_PROJECT, COORD_MAX, COORD_MIN, '0);
      send_vertex(OP_PROJECT, 24'h001000, 24'hfff000, COORD_W'(-3174400));
      send_vertex(OP_PROJECT, COORD_MAX, COORD_MAX, COORD_MIN);
      send_vertex(OP_PROJECT, 24'h000001, 24'hffffff, COORD_W'(-3174399));
      send_vertex(OP_PROJECT, 24'h100000, 24'h0ff000, COORD_MAX);
      drain();

      // rounding ties and full-scale trig values
      write_reg(REG_COS_X, 23'd1);
      write_reg(REG_SIN_X, '0);
      write_reg(REG_COS_Y, 23'h004000);
      write_reg(REG_SIN_Y, 23'h004000);
      write_reg(REG_COS_Z, 23'h00c000);
      write_reg(REG_SIN_Z, 23'h00c000);
      write_reg(REG_FOCAL, 23'd4097);
      write_reg(REG_CENTRE, 23'd4095);
      csr_valid <= 1'b0;
      send_vertex(OP_ROT_X, '0, 24'd8192, '0);
      send_vertex(OP_ROT_X, '0, COORD_W'(-8192), '0);
      send_vertex(OP_ROT_Y, COORD_MAX, 24'd5, COORD_MIN);
      send_vertex(OP_ROT_Z, COORD_MAX, COORD_MAX, 24'd7);
      send_vertex(OP_ROT_Z, COORD_MIN, COORD_MIN, '0);
      send_vertex(OP_PROJECT, 24'h000001, 24'hffffff, COORD_W'(-4095));
      send_vertex(OP_PROJECT, COORD_MAX, COORD_MIN, '0);
      send_vertex(OP_PROJECT, 24'd3, 24'd3, COORD_W'(-4097));
      drain();

      // out-of-range values, masked upper data bits, unused indexes
      for (int i = REG_COS_X; i <= REG_SIN_Z; i++) begin
         write_reg(CSR_IDX_W'(i), 23'h7f8000);
      end
      write_reg(REG_FOCAL, '0);
      write_reg(REG_CENTRE, 23'h7ff000);
      write_reg(CSR_IDX_W'(REG_CENTRE + 1), 23'h5a5a5a);
      write_reg(REG_INDEX_TOP, FOCAL_W'($urandom));
      csr_valid <= 1'b0;
      send_vertex(OP_ROT_X, '0, COORD_MAX, COORD_MAX);
      send_vertex(OP_ROT_Y, COORD_MAX, '0, COORD_MAX);
      send_vertex(OP_ROT_Z, COORD_MIN, COORD_MAX, '0);
      send_vertex(OP_PROJECT, COORD_MAX, COORD_MIN, 24'd1);
      send_vertex(OP_PROJECT, 24'd5, 24'd5, '0);
      drain();

      burst_left = $urandom_range(1, 40);
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         randomize_registers();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_vertex();
            burst_left--;
            if (phase == 0 && n == PHASE_ITEMS / 2) begin
               drain();
            end else if (burst_left <= 0) begin
               hold_off($urandom_range(1, 12));
               burst_left = $urandom_range(1, 40);
            end
         end
         drain();
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
